// File: rtl/core/ambient_light_backlight_scale_assert.svh
// Assertion macros shared by the ambient light backlight scale RTL.
`ifndef AMBIENT_LIGHT_BACKLIGHT_SCALE_ASSERT_SVH
`define AMBIENT_LIGHT_BACKLIGHT_SCALE_ASSERT_SVH
`ifndef SYNTHESIS
`define ALB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("alb assertion failed");
`define ALB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("alb assertion failed");
`define ALB_ASSERT_DLY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##dly (cons)) \
        else $error("alb assertion failed");
`else
`define ALB_ASSERT_IMP(lbl, ante, cons)
`define ALB_ASSERT_NEXT(lbl, ante, cons)
`define ALB_ASSERT_DLY(lbl, ante, dly, cons)
`endif
`endif

// File: rtl/core/alb_pkg.sv
// Shared types, constants and the restoring division step.
package alb_pkg;

    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [15:0] LOW_TH_RST  = 16'd150;
    localparam logic [15:0] HIGH_TH_RST = 16'd1000;
    localparam logic [15:0] MIN_LUM_RST = 16'd15;
    localparam logic [14:0] MAX_LUM_RST = 15'd350;
    localparam logic [15:0] REFL_RST    = 16'd7427;

    localparam logic [31:0] HALF_ROUND_12 = 32'd2048;
    localparam logic [31:0] HALF_ROUND_16 = 32'd32768;
    localparam logic [31:0] TOP_ROUND_6   = 32'd32;
    localparam logic [15:0] ALL_ONES      = 16'hFFFF;

    typedef enum logic [2:0] {
        CFG_LOW_TH  = 3'd0,
        CFG_HIGH_TH = 3'd1,
        CFG_MIN_LUM = 3'd2,
        CFG_MAX_LUM = 3'd3,
        CFG_REFL    = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        RG_LOW  = 2'd0,
        RG_MID  = 2'd1,
        RG_HIGH = 2'd2
    } t_region;

    // calibration handed from the register block to the datapath
    typedef struct packed {
        logic [15:0] lo_th;
        logic [15:0] hi_th;
        logic [15:0] min_lum;
        logic [14:0] max_lum;
        logic [15:0] refl;
        logic [15:0] lo_ratio;
        logic [15:0] hi_ratio;
        logic [15:0] span;
    } t_cal;

    typedef struct packed {
        logic [15:0] rem;
        logic [31:0] d;
    } t_div;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic t_div div_step(input logic [15:0] rem, input logic [31:0] d,
                                      input logic [15:0] den);
        logic [16:0] part;
        logic [16:0] diff;
        logic        ge;
        t_div        res;
        part    = {rem, d[31]};
        diff    = part - {1'b0, den};
        ge      = (part >= {1'b0, den});
        res.rem = ge ? diff[15:0] : part[15:0];
        res.d   = {d[30:0], ge};
        return res;
    endfunction

endpackage

// File: rtl/core/ambient_light_backlight_scale.sv
// One request per cycle while busy is low; a request is only accepted when busy is low.
// Three 32-stage divider pipelines make up most of the path; results cannot be held off.
// busy is high after reset and after each register write,
// while the two lux ratios are recomputed by a serial one-bit-per-cycle divider.
// Reset (i_rst_n low, synchronous) loads register defaults and empties the pipeline.
module ambient_light_backlight_scale import alb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_ambient_lux,
    output logic        o_strobe,
    output logic [15:0] o_scale_factor,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

`include "ambient_light_backlight_scale_assert.svh"

    localparam int LATENCY = 3 * DIV_STEPS + 8;

    t_cal w_cal;
    logic w_accept;

    assign w_accept = start && !busy;

    alb_cal u_cal (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cal       (w_cal),
        .o_busy      (busy)
    );

    alb_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_lux   (i_ambient_lux),
        .i_cal   (w_cal),
        .o_valid (o_strobe),
        .o_scale (o_scale_factor)
    );

    `ALB_ASSERT_NEXT(a_wr_busy, i_cfg_valid && o_cfg_ready, busy)
    `ALB_ASSERT_DLY(a_latency, w_accept, LATENCY, o_strobe)
    `ALB_ASSERT_IMP(a_zero_norm, o_strobe && (w_cal.max_lum == '0), o_scale_factor == ALL_ONES)

endmodule

// File: rtl/core/alb_div_pipe.sv
// Pipelined 32 by 16 restoring divider, one quotient bit per stage.
module alb_div_pipe import alb_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [31:0]       i_num,
    input  logic [15:0]       i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [31:0]       o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_v    [DIV_STEPS];
    logic [15:0]       r_rem  [DIV_STEPS];
    logic [31:0]       r_d    [DIV_STEPS];
    logic [15:0]       r_den  [DIV_STEPS];
    logic [SIDE_W-1:0] r_side [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_stage
        logic              s_v;
        logic [15:0]       s_rem;
        logic [31:0]       s_d;
        logic [15:0]       s_den;
        logic [SIDE_W-1:0] s_side;
        t_div              n_step;

        // pick the stage input: the ports or the previous stage
        if (j == 0) begin : g_first
            assign s_v    = i_valid;
            assign s_rem  = '0;
            assign s_d    = i_num;
            assign s_den  = i_den;
            assign s_side = i_side;
        end else begin : g_next
            assign s_v    = r_v[j-1];
            assign s_rem  = r_rem[j-1];
            assign s_d    = r_d[j-1];
            assign s_den  = r_den[j-1];
            assign s_side = r_side[j-1];
        end

        assign n_step = div_step(s_rem, s_d, s_den);

        // advance the valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= s_v;
            end
        end

        // advance the partial remainder and quotient
        always_ff @(posedge i_clk) begin
            r_rem[j]  <= n_step.rem;
            r_d[j]    <= n_step.d;
            r_den[j]  <= s_den;
            r_side[j] <= s_side;
        end
    end

    assign o_valid = r_v[DIV_STEPS-1];
    assign o_quo   = r_d[DIV_STEPS-1];
    assign o_side  = r_side[DIV_STEPS-1];

endmodule

// File: rtl/core/alb_cal.sv
// Configuration registers and the sequential lux ratio calculation.
module alb_cal import alb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output t_cal        o_cal,
    output logic        o_busy
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_PREP = 4'b0100,
        ST_DIV  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic               r_sel, n_sel;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [15:0]        r_lo_th, r_hi_th, r_min_lum, r_refl;
    logic [14:0]        r_max_lum;
    logic [31:0]        r_prod;
    logic [15:0]        r_rem;
    logic [31:0]        r_dq;
    logic [15:0]        r_den;
    logic [15:0]        r_lo_ratio, r_hi_ratio;

    logic               cfg_wr;
    logic [15:0]        lum, lux;
    logic [31:0]        rnd;
    logic [19:0]        tot_sum;
    logic [15:0]        total;
    logic [16:0]        tot_inc;
    logic [31:0]        scaled;
    logic               special;
    logic [15:0]        special_val;
    t_div               step;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign o_busy      = (r_state != ST_IDLE);

    // operands of the ratio being worked on
    assign lum = r_sel ? {1'b0, r_max_lum} : r_min_lum;
    assign lux = r_sel ? r_hi_th : r_lo_th;

    // rounded reflected total and scaled numerator
    assign rnd     = r_prod + HALF_ROUND_12;
    assign tot_sum = rnd[31:12] + {lum, 4'b0};
    assign total   = tot_sum[15:0];
    assign tot_inc = {1'b0, total} + 17'd1;
    assign scaled  = {lum[11:0], 20'b0} + {16'b0, tot_inc[16:1]};

    always_comb begin
        special     = 1'b1;
        special_val = ALL_ONES;
        if (lum == '0 && lux == '0) begin
            special_val = '0;
        end else if (scaled == {total, 16'b0} || total == '0) begin
            special_val = ALL_ONES;
        end else begin
            special = 1'b0;
        end
    end

    assign step = div_step(r_rem, r_dq, r_den);

    // sequence the two ratios; any write restarts the sweep
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_state = ST_IDLE;
            end
            ST_MUL: begin
                n_state = ST_PREP;
            end
            ST_PREP: begin
                n_cnt = '0;
                if (special) begin
                    n_state = r_sel ? ST_IDLE : ST_MUL;
                    n_sel   = 1'b1;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = r_sel ? ST_IDLE : ST_MUL;
                    n_sel   = 1'b1;
                end
            end
            default: begin
                n_state = ST_MUL;
                n_sel   = 1'b0;
            end
        endcase
        if (cfg_wr) begin
            n_state = ST_MUL;
            n_sel   = 1'b0;
        end
    end

    // hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_MUL;
            r_sel   <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_cnt   <= n_cnt;
        end
    end

    // take register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo_th   <= LOW_TH_RST;
            r_hi_th   <= HIGH_TH_RST;
            r_min_lum <= MIN_LUM_RST;
            r_max_lum <= MAX_LUM_RST;
            r_refl    <= REFL_RST;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_LOW_TH:  r_lo_th   <= i_cfg_data;
                CFG_HIGH_TH: r_hi_th   <= i_cfg_data;
                CFG_MIN_LUM: r_min_lum <= i_cfg_data;
                CFG_MAX_LUM: r_max_lum <= i_cfg_data[14:0];
                CFG_REFL:    r_refl    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ratio datapath: product, setup, serial division, store
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            r_prod <= {32'(lux * r_refl) << 1};
        end
        if (r_state == ST_PREP) begin
            r_rem <= '0;
            r_dq  <= scaled;
            r_den <= total;
            if (special) begin
                if (r_sel) begin
                    r_hi_ratio <= special_val;
                end else begin
                    r_lo_ratio <= special_val;
                end
            end
        end
        if (r_state == ST_DIV) begin
            r_rem <= step.rem;
            r_dq  <= step.d;
            if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                if (r_sel) begin
                    r_hi_ratio <= step.d[15:0];
                end else begin
                    r_lo_ratio <= step.d[15:0];
                end
            end
        end
    end

    assign o_cal.lo_th    = r_lo_th;
    assign o_cal.hi_th    = r_hi_th;
    assign o_cal.min_lum  = r_min_lum;
    assign o_cal.max_lum  = r_max_lum;
    assign o_cal.refl     = r_refl;
    assign o_cal.lo_ratio = r_lo_ratio;
    assign o_cal.hi_ratio = r_hi_ratio;
    assign o_cal.span     = r_hi_th - r_lo_th;

endmodule

// File: rtl/core/alb_pipe.sv
// Per-reading datapath: interpolation, reflected light and normalisation.
module alb_pipe import alb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [15:0] i_lux,
    input  t_cal        i_cal,
    output logic        o_valid,
    output logic [15:0] o_scale
);

    // stage A: classify the reading
    logic        rA_v;
    t_region     rA_rg;
    logic [15:0] rA_amb, rA_dh, rA_dl;
    t_region     rg;

    always_comb begin
        if (i_cal.lo_th >= i_lux) begin
            rg = RG_LOW;
        end else if (i_lux < i_cal.hi_th) begin
            rg = RG_MID;
        end else begin
            rg = RG_HIGH;
        end
    end

    // stage B: low ratio product and room product
    logic        rB_v;
    t_region     rB_rg;
    logic [15:0] rB_dl;
    logic [31:0] rB_p1, rB_pr;

    // stage C: high ratio product and room lux
    logic        rC_v;
    t_region     rC_rg;
    logic [31:0] rC_p1, rC_p2;
    logic [15:0] rC_room;
    logic [31:0] pr_rnd;

    // stage D: interpolation numerator
    logic        rD_v;
    t_region     rD_rg;
    logic [15:0] rD_room;
    logic [31:0] rD_num;
    logic [16:0] span_inc;

    assign pr_rnd   = rB_pr + HALF_ROUND_16;
    assign span_inc = {1'b0, i_cal.span} + 17'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rA_v <= 1'b0;
            rB_v <= 1'b0;
            rC_v <= 1'b0;
            rD_v <= 1'b0;
        end else begin
            rA_v <= i_valid;
            rB_v <= rA_v;
            rC_v <= rB_v;
            rD_v <= rC_v;
        end
    end

    always_ff @(posedge i_clk) begin
        rA_rg   <= rg;
        rA_amb  <= i_lux;
        rA_dh   <= i_cal.hi_th - i_lux;
        rA_dl   <= i_lux - i_cal.lo_th;
        rB_rg   <= rA_rg;
        rB_dl   <= rA_dl;
        rB_p1   <= i_cal.lo_ratio * rA_dh;
        rB_pr   <= 32'(i_cal.refl * {rA_amb, 7'b0});
        rC_rg   <= rB_rg;
        rC_p1   <= rB_p1;
        rC_p2   <= i_cal.hi_ratio * rB_dl;
        rC_room <= pr_rnd[31:16];
        rD_rg   <= rC_rg;
        rD_room <= rC_room;
        rD_num  <= rC_p1 + rC_p2 + {16'b0, span_inc[16:1]};
    end

    // divide by the threshold span
    logic        d1_v;
    logic [31:0] d1_q;
    logic [17:0] d1_side;

    alb_div_pipe #(.SIDE_W(18)) u_div_int (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rD_v),
        .i_num   (rD_num),
        .i_den   (i_cal.span),
        .i_side  ({rD_rg, rD_room}),
        .o_valid (d1_v),
        .o_quo   (d1_q),
        .o_side  (d1_side)
    );

    // stages E and F: reflected light numerator and divisor
    logic        rE_v, rF_v;
    t_region     rE_rg, rF_rg;
    logic [31:0] rE_prod, rF_num;
    logic [15:0] rE_den, rF_den;
    logic [15:0] intensity;
    logic [16:0] den_inc;

    assign intensity = d1_q[15:0];
    assign den_inc   = {1'b0, rE_den} + 17'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rE_v <= 1'b0;
            rF_v <= 1'b0;
        end else begin
            rE_v <= d1_v;
            rF_v <= rE_v;
        end
    end

    always_ff @(posedge i_clk) begin
        rE_rg   <= t_region'(d1_side[17:16]);
        rE_prod <= intensity * d1_side[15:0];
        rE_den  <= (intensity != '0) ? (16'd0 - intensity) : ALL_ONES;
        rF_rg   <= rE_rg;
        rF_den  <= rE_den;
        rF_num  <= rE_prod + {16'b0, den_inc[16:1]};
    end

    // divide by the reflected-light divisor
    logic        d2_v;
    logic [31:0] d2_q;
    logic [1:0]  d2_side;

    alb_div_pipe #(.SIDE_W(2)) u_div_refl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rF_v),
        .i_num   (rF_num),
        .i_den   (rF_den),
        .i_side  (rF_rg),
        .o_valid (d2_v),
        .o_quo   (d2_q),
        .o_side  (d2_side)
    );

    // stage G: pick the reference light and build the normalising numerator
    logic        rG_v;
    logic [31:0] rG_num;
    logic        rG_zero;
    logic [31:0] q_rnd;
    logic [15:0] ref_light;

    assign q_rnd = d2_q + TOP_ROUND_6;

    always_comb begin
        case (t_region'(d2_side))
            RG_LOW:  ref_light = i_cal.min_lum;
            RG_MID:  ref_light = q_rnd[21:6];
            RG_HIGH: ref_light = {1'b0, i_cal.max_lum};
            default: ref_light = {1'b0, i_cal.max_lum};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rG_v <= 1'b0;
        end else begin
            rG_v <= d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        rG_num  <= {ref_light, 16'b0} + {17'b0, i_cal.max_lum};
        rG_zero <= (i_cal.max_lum == '0);
    end

    // divide by twice the maximum luminance
    logic        d3_v;
    logic [31:0] d3_q;
    logic        d3_zero;

    alb_div_pipe #(.SIDE_W(1)) u_div_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rG_v),
        .i_num   (rG_num),
        .i_den   ({i_cal.max_lum, 1'b0}),
        .i_side  (rG_zero),
        .o_valid (d3_v),
        .o_quo   (d3_q),
        .o_side  (d3_zero)
    );

    // stage H: output register, all ones on a zero normaliser
    logic        rH_v;
    logic [15:0] rH_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rH_v <= 1'b0;
        end else begin
            rH_v <= d3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        rH_scale <= d3_zero ? ALL_ONES : d3_q[15:0];
    end

    assign o_valid = rH_v;
    assign o_scale = rH_scale;

endmodule

// File: dv/ambient_light_backlight_scale_checker.sv
// Scoreboard for the backlight scale block: predicts each scale factor and compares it.
`timescale 1ns / 100ps
module ambient_light_backlight_scale_checker import alb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [15:0] i_ambient_lux,
    input  logic        i_strobe,
    input  logic [15:0] i_scale_factor,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    logic [31:0] lo_th, hi_th, min_lum, max_lum, refl;
    logic [15:0] scale_q[$];

    // divide, or all ones on a zero divisor
    function automatic logic [31:0] div_sat(input logic [31:0] n, input logic [31:0] d);
        logic [31:0] q;
        if (d == 32'd0) return 32'h0000_FFFF;
        q = n / d;
        return {16'd0, q[15:0]};
    endfunction

    function automatic logic [31:0] lux_ratio(input logic [31:0] lum, input logic [31:0] lux);
        logic [31:0] total, scaled;
        if (lum == 32'd0 && lux == 32'd0) return 32'd0;
        total = ((((32'd2 * lux * refl) + HALF_ROUND_12) >> 12) + 32'd16 * lum)
                & 32'h0000_FFFF;
        scaled = (lum << 20) + ((total + 32'd1) >> 1);
        if (scaled == (total << 16)) return 32'h0000_FFFF;
        return div_sat(scaled, total);
    endfunction

    function automatic logic [15:0] predict_scale(input logic [15:0] lux_in);
        logic [31:0] amb, ref_lum, lo_r, hi_r, span, num, v, den, room, q;
        amb = {16'd0, lux_in};
        if (lo_th >= amb) begin
            ref_lum = min_lum;
        end else if (amb < hi_th) begin
            // reflected-light estimate between the thresholds
            lo_r = lux_ratio(min_lum, lo_th);
            hi_r = lux_ratio(max_lum, hi_th);
            span = (hi_th - lo_th) & 32'h0000_FFFF;
            num  = lo_r * (hi_th - amb) + hi_r * (amb - lo_th) + ((span + 32'd1) >> 1);
            v    = div_sat(num, span);
            den  = (v != 32'd0) ? ((32'd0 - v) & 32'h0000_FFFF) : 32'h0000_FFFF;
            room = (refl * (amb << 7) + HALF_ROUND_16) >> 16;
            q    = (v * room + ((den + 32'd1) >> 1)) / den;
            ref_lum = ((q + TOP_ROUND_6) >> 6) & 32'h0000_FFFF;
        end else begin
            ref_lum = max_lum;
        end
        num = max_lum + (ref_lum << 16);
        q   = div_sat(num, (32'd2 * max_lum) & 32'h0000_FFFF);
        return q[15:0];
    endfunction

    assign o_pending = scale_q.size();

    initial o_errors = 0;

    // track registers, queue predictions, compare results
    always @(posedge i_clk) begin
        logic [15:0] want;
        if (!i_rst_n) begin
            lo_th   = LOW_TH_RST;
            hi_th   = HIGH_TH_RST;
            min_lum = MIN_LUM_RST;
            max_lum = MAX_LUM_RST;
            refl    = REFL_RST;
            scale_q.delete();
        end else begin
            if (i_strobe) begin
                if (scale_q.size() == 0) begin
                    $display("%0t: unexpected scale factor %0d", $time, i_scale_factor);
                    o_errors++;
                end else begin
                    want = scale_q.pop_front();
                    if (want !== i_scale_factor) begin
                        $display("%0t: scale factor mismatch, expected %0d, actual %0d",
                                 $time, want, i_scale_factor);
                        o_errors++;
                    end
                end
            end
            if (i_start && !i_busy) scale_q.push_back(predict_scale(i_ambient_lux));
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_LOW_TH:  lo_th   = {16'd0, i_cfg_data};
                    CFG_HIGH_TH: hi_th   = {16'd0, i_cfg_data};
                    CFG_MIN_LUM: min_lum = {16'd0, i_cfg_data};
                    CFG_MAX_LUM: max_lum = {17'd0, i_cfg_data[14:0]};
                    CFG_REFL:    refl    = {16'd0, i_cfg_data};
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: dv/ambient_light_backlight_scale_test.sv
// Stimulus and verdict for the backlight scale block across several calibrations.
`timescale 1ns / 100ps
module ambient_light_backlight_scale_test;
    import alb_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] i_ambient_lux;
    logic        o_strobe;
    logic [15:0] o_scale_factor;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    int          errors;
    int          pending;
    int          idle_pct;
    int          sent;
    int          settings;
    logic [15:0] cur_lo, cur_hi;

    ambient_light_backlight_scale dut (.*);

    ambient_light_backlight_scale_checker scoreboard (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_ambient_lux,
        .i_strobe(o_strobe), .i_scale_factor(o_scale_factor), .i_cfg_valid,
        .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending));

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    // hold a request until the block takes it; start stays high afterwards
    task automatic send_request(input logic [15:0] lux);
        logic took;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_ambient_lux <= lux;
        do begin
            @(negedge i_clk);
            took = !busy;
            @(posedge i_clk);
        end while (!took);
        sent++;
    endtask

    // drain every expected result, then let the pipeline empty
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        logic took;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(negedge i_clk);
            took = o_cfg_ready;
            @(posedge i_clk);
        end while (!took);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic calibrate(input logic [15:0] lo, input logic [15:0] hi,
                             input logic [15:0] mn, input logic [14:0] mx,
                             input logic [15:0] rc);
        drain();
        write_reg(CFG_LOW_TH, lo);
        write_reg(CFG_HIGH_TH, hi);
        write_reg(CFG_MIN_LUM, mn);
        write_reg(CFG_MAX_LUM, {1'($urandom_range(1)), mx});
        write_reg(CFG_REFL, rc);
        cur_lo = lo;
        cur_hi = hi;
        settings++;
    endtask

    // mostly readings near and between the thresholds, some anywhere
    function automatic logic [15:0] pick_lux();
        int unsigned a, b;
        a = (cur_lo < cur_hi) ? cur_lo : cur_hi;
        b = (cur_lo < cur_hi) ? cur_hi : cur_lo;
        case ($urandom_range(9))
            0, 1, 2: return 16'($urandom);
            3:       return 16'(a + $urandom_range(2) - 1);
            4:       return 16'(b + $urandom_range(2) - 1);
            default: return 16'($urandom_range(b, a));
        endcase
    endfunction

    task automatic random_run(input int count);
        repeat (count) send_request(pick_lux());
    endtask

    initial begin
        logic [15:0] edge_lux [14];
        edge_lux      = '{16'd0, 16'd1, 16'd149, 16'd150, 16'd151, 16'd500,
                          16'd999, 16'd1000, 16'd1001, 16'h7FFF, 16'h8000,
                          16'hAAAA, 16'h5555, 16'hFFFF};
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_ambient_lux = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_LOW_TH;
        i_cfg_data    = '0;
        idle_pct      = 0;
        sent          = 0;
        settings      = 1;
        cur_lo        = LOW_TH_RST;
        cur_hi        = HIGH_TH_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset calibration: threshold edges and field extremes
        foreach (edge_lux[i]) send_request(edge_lux[i]);

        // extreme calibrations
        calibrate(16'd0, 16'hFFFF, 16'hFFFF, 15'h7FFF, 16'hFFFF);
        foreach (edge_lux[i]) send_request(edge_lux[i]);
        calibrate(16'd0, 16'd0, 16'd0, 15'd1, 16'd0);
        send_request(16'd0);
        send_request(16'd1);
        calibrate(16'd2000, 16'd100, 16'd7, 15'd3, 16'd1);
        send_request(16'd100);
        send_request(16'd2000);
        send_request(16'd2001);

        // random calibrations under shifting sender idling
        for (int ph = 0; ph < 9; ph++) begin
            idle_pct = (ph < 3) ? 32 : (ph < 6) ? 45 : 0;
            case (ph % 3)
                0: calibrate(16'($urandom_range(400)), 16'($urandom_range(65535, 500)),
                             16'($urandom), 15'($urandom_range(32767, 1)),
                             16'($urandom));
                1: calibrate(16'($urandom), 16'($urandom), 16'($urandom_range(30)),
                             15'($urandom_range(40, 1)), 16'($urandom_range(16000)));
                default: calibrate(16'($urandom_range(300)), 16'($urandom_range(3000, 300)),
                                   16'($urandom_range(100)),
                                   15'($urandom_range(1000, 1)), 16'($urandom_range(9000)));
            endcase
            random_run(30);
            // let everything settle once mid-phase
            if (ph == 4) drain();
            random_run(33);
        end

        drain();
        $display("covered %0d readings over %0d calibrations, thresholds crossed both ways",
                 sent, settings);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
